FILE: hw/rtl/wnt_pkg.sv
package wnt_pkg;

    // Sizing
    localparam int unsigned MAX_WAYPOINTS_DEF = 1024;
    localparam int unsigned TABLE_LIMIT       = 1024;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 10;
    localparam int COORD_W = 24;
    localparam int DIST_W  = 25;
    localparam int NUM_W   = 11;
    localparam int RANGE_W = 10;

    // Squared distance: two squares of 25-bit differences
    localparam int D2_W       = 50;
    localparam int ROOT_STEPS = 25;
    localparam int ROOT_CNT_W = 5;

    localparam logic [DIST_W-1:0] DIST_SAT = '1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REWIND = 2'd2;

    // Configuration registers
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_WAYPOINTS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SPAN   = 1'd1;
    localparam logic [RANGE_W-1:0]     WINDOW_SPAN_RST   = 10'd16;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [IDX_W-1:0]          waypoint_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
    } wnt_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  closest_index;
        logic [DIST_W-1:0] nearest_dist;
        logic              table_empty;
    } wnt_result_t;

    // Controller to datapath
    typedef struct packed {
        logic wr_en;
        logic rewind;
        logic query_init;
        logic rd_en;
        logic root_init;
        logic root_step;
        logic publish;
    } wnt_ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic table_empty;
        logic scan_more;
        logic pipe_busy;
        logic found;
        logic root_last;
    } wnt_stat_t;

endpackage

FILE: hw/rtl/wnt_ram.sv
module wnt_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/wnt_ctrl.sv
module wnt_ctrl
    import wnt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] command,
    input  wnt_stat_t        stat,
    output logic             busy,
    output logic             done,
    output wnt_ctrl_t        ctrl
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_ROOT  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (command)
                        CMD_LOAD:
                        begin
                            ctrl.wr_en = 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            ctrl.query_init = 1'b1;
                            state_next = stat.table_empty ? ST_OUT : ST_SCAN;
                        end
                        CMD_REWIND:
                        begin
                            ctrl.rewind = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                ctrl.rd_en = stat.scan_more;
                if (!stat.scan_more)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for the distance pipe to empty
                if (!stat.pipe_busy)
                begin
                    if (stat.found)
                    begin
                        ctrl.root_init = 1'b1;
                        state_next     = ST_ROOT;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_ROOT:
            begin
                ctrl.root_step = 1'b1;
                if (stat.root_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                ctrl.publish = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_OUT);

endmodule

FILE: hw/rtl/wnt_datapath.sv
module wnt_datapath
    import wnt_pkg::*;
#(
    parameter int unsigned MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wnt_item_t              in_item,
    input  wnt_ctrl_t              ctrl,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output wnt_stat_t              stat,
    output wnt_result_t            result
);

    localparam int unsigned DEPTH =
        (MAX_WAYPOINTS < TABLE_LIMIT) ? MAX_WAYPOINTS : TABLE_LIMIT;
    localparam int AW = $clog2(DEPTH);
    localparam logic [NUM_W-1:0] DEPTH_N = NUM_W'(DEPTH);
    localparam int ENTRY_W = 2 * COORD_W;

    // Configuration registers
    logic [NUM_W-1:0]   num_wp_reg;
    logic [RANGE_W-1:0] range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_wp_reg <= '0;
            range_reg  <= WINDOW_SPAN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_WAYPOINTS: num_wp_reg <= cfg_data[NUM_W-1:0];
                REG_WINDOW_SPAN:   range_reg  <= cfg_data[RANGE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Entries in use, clipped to the table depth
    logic [NUM_W-1:0] n_use;
    assign n_use = (num_wp_reg > DEPTH_N) ? DEPTH_N : num_wp_reg;

    // Waypoint table, {x, y} per entry
    logic             ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [NUM_W-1:0] scan_idx_reg;
    logic [NUM_W-1:0] stop_reg;

    assign ram_we = ctrl.wr_en && (32'(in_item.waypoint_index) < MAX_WAYPOINTS);

    wnt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (in_item.waypoint_index[AW-1:0]),
        .wr_data ({in_item.pos_x, in_item.pos_y}),
        .rd_en   (ctrl.rd_en),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // Tracking index
    logic [IDX_W-1:0] tracking_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic             empty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg <= '0;
        end
        else if (ctrl.rewind)
        begin
            tracking_reg <= in_item.waypoint_index;
        end
        else if (ctrl.publish && !empty_reg)
        begin
            tracking_reg <= best_idx_reg;
        end
    end

    // Window bounds
    logic [NUM_W-1:0] win_end;
    logic [NUM_W-1:0] last_idx;
    logic [NUM_W-1:0] stop_next;

    assign win_end   = {1'b0, tracking_reg} + {1'b0, range_reg};
    assign last_idx  = n_use - NUM_W'(1);
    assign stop_next = (win_end > last_idx) ? last_idx : win_end;

    logic signed [COORD_W-1:0] px_reg;
    logic signed [COORD_W-1:0] py_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.query_init)
        begin
            px_reg       <= in_item.pos_x;
            py_reg       <= in_item.pos_y;
            scan_idx_reg <= {1'b0, tracking_reg};
            stop_reg     <= stop_next;
        end
        else if (ctrl.rd_en)
        begin
            scan_idx_reg <= scan_idx_reg + NUM_W'(1);
        end
    end

    // Distance pipe: read, difference, square, compare
    logic                    v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]        idx1_reg, idx2_reg, idx3_reg;
    logic signed [COORD_W:0] dx_reg, dy_reg;
    logic [D2_W-1:0]         sqx_reg, sqy_reg;

    logic signed [COORD_W-1:0] wx;
    logic signed [COORD_W-1:0] wy;
    logic signed [D2_W-1:0]    sqx_full;
    logic signed [D2_W-1:0]    sqy_full;

    assign wx       = ram_rdata[ENTRY_W-1:COORD_W];
    assign wy       = ram_rdata[COORD_W-1:0];
    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= scan_idx_reg[IDX_W-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        dx_reg   <= {wx[COORD_W-1], wx} - {px_reg[COORD_W-1], px_reg};
        dy_reg   <= {wy[COORD_W-1], wy} - {py_reg[COORD_W-1], py_reg};
        sqx_reg  <= unsigned'(sqx_full);
        sqy_reg  <= unsigned'(sqy_full);
    end

    // Running minimum, first minimum wins
    logic [D2_W-1:0] d2;
    logic [D2_W-1:0] best_d2_reg;
    logic            found_reg;

    assign d2 = sqx_reg + sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            empty_reg <= 1'b0;
        end
        else if (ctrl.query_init)
        begin
            found_reg <= 1'b0;
            empty_reg <= (n_use == '0);
        end
        else if (v3_reg)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.query_init)
        begin
            best_idx_reg <= tracking_reg;
        end
        else if (v3_reg && (!found_reg || d2 < best_d2_reg))
        begin
            best_d2_reg  <= d2;
            best_idx_reg <= idx3_reg;
        end
    end

    // Integer square root, one result bit per cycle
    logic [D2_W-1:0]       rem_reg;
    logic [D2_W-1:0]       root_reg;
    logic [D2_W-1:0]       bit_reg;
    logic [ROOT_CNT_W-1:0] cnt_reg;
    logic [D2_W-1:0]       trial;

    assign trial = root_reg + bit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.root_init)
        begin
            rem_reg  <= best_d2_reg;
            root_reg <= '0;
            bit_reg  <= D2_W'(1) << (D2_W - 2);
            cnt_reg  <= ROOT_CNT_W'(ROOT_STEPS - 1);
        end
        else if (ctrl.root_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            cnt_reg <= cnt_reg - ROOT_CNT_W'(1);
        end
    end

    // Status
    assign stat.table_empty = (n_use == '0);
    assign stat.scan_more   = (scan_idx_reg <= stop_reg) && (scan_idx_reg < n_use);
    assign stat.pipe_busy   = v1_reg || v2_reg || v3_reg;
    assign stat.found       = found_reg;
    assign stat.root_last   = (cnt_reg == '0);

    // Result fields, held through the output cycle
    assign result.closest_index = empty_reg ? '0 : best_idx_reg;
    assign result.nearest_dist  = !found_reg ? DIST_SAT :
                                  (root_reg > D2_W'(DIST_SAT)) ? DIST_SAT :
                                  root_reg[DIST_W-1:0];
    assign result.table_empty   = empty_reg;

endmodule

FILE: hw/rtl/windowed_nearest_waypoint_tracker.sv
// Windowed nearest-waypoint tracker.
// Input items arrive on cmd and are taken when start is high and busy is low.
// Command load writes one waypoint into the table, rewind sets the tracking
// index; neither gives a result. A query searches the window from the
// tracking index up to the index plus the search range (clipped to the last
// waypoint in use), one stored waypoint per cycle through a four-stage
// distance pipe, then runs a bit-serial integer square root of 25 steps.
// A query holds busy while it reads each window entry, drains the pipe, takes
// the 25 root steps and gives the output cycle. An empty table or an empty
// window skips the search and root. done is high for exactly one cycle with
// the result on result; the receiver cannot stall it. Configuration writes go
// through cfg_valid/cfg_data at cfg_index (0 waypoint count, 1 search range);
// cfg_ready is always high. The user must make writes only while busy is low;
// the block itself does not enforce this rule.
// Reset clears the tracking index, the waypoint count (0) and the range (16);
// the waypoint table is not cleared and entries are undefined until loaded.
module windowed_nearest_waypoint_tracker
    import wnt_pkg::*;
#(
    parameter int unsigned MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  wnt_item_t              cmd,
    output logic                   done,
    output wnt_result_t            result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    wnt_ctrl_t ctrl;
    wnt_stat_t stat;

    assign cfg_ready = 1'b1;

    wnt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (cmd.command),
        .stat    (stat),
        .busy    (busy),
        .done    (done),
        .ctrl    (ctrl)
    );

    wnt_datapath #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (cmd),
        .ctrl      (ctrl),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .result    (result)
    );

endmodule

FILE: dv/wnt_checker.sv
module wnt_checker
    import wnt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  wnt_item_t              cmd,
    input  logic                   done,
    input  wnt_result_t            result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the table, tracking index and registers
    int          wp_x [MAX_WAYPOINTS_DEF];
    int          wp_y [MAX_WAYPOINTS_DEF];
    int unsigned track_idx = 0;
    int unsigned num_wp    = 0;
    int unsigned span      = WINDOW_SPAN_RST;

    // Predicted answers of accepted queries, oldest first
    wnt_result_t answers [$];
    wnt_result_t oldest;

    // Floor square root, settling one root bit per pass from the top
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        int              b;
        root = 0;
        for (b = DIST_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Nearest loaded waypoint in the search window; moves the tracking index
    function automatic wnt_result_t nearest_in_window(int px, int py);
        wnt_result_t     res;
        int unsigned     n;
        int unsigned     last;
        int unsigned     best;
        int unsigned     i;
        longint          dx;
        longint          dy;
        longint unsigned d2;
        longint unsigned best_d2;
        longint unsigned root;
        bit              found;
        n = (num_wp > MAX_WAYPOINTS_DEF) ? MAX_WAYPOINTS_DEF : num_wp;
        if (n > TABLE_LIMIT)
            n = TABLE_LIMIT;
        res.closest_index = '0;
        res.nearest_dist  = DIST_SAT;
        res.table_empty   = 1'b0;
        // nothing loaded: flag it, index stays put
        if (n == 0)
        begin
            res.table_empty = 1'b1;
            return res;
        end
        last = track_idx + span;
        if (last > n - 1)
            last = n - 1;
        best    = track_idx;
        best_d2 = 0;
        found   = 1'b0;
        // strict less-than keeps the first of equal distances
        for (i = track_idx; i <= last && i < n; i++)
        begin
            dx = longint'(wp_x[i]) - longint'(px);
            dy = longint'(wp_y[i]) - longint'(py);
            d2 = longint'(dx * dx + dy * dy);
            if (!found || d2 < best_d2)
            begin
                best_d2 = d2;
                best    = i;
                found   = 1'b1;
            end
        end
        track_idx         = best % MAX_WAYPOINTS_DEF;
        res.closest_index = IDX_W'(track_idx);
        // an index past the end leaves the distance saturated
        if (found)
        begin
            root             = floor_sqrt(best_d2);
            res.nearest_dist = (root > DIST_SAT) ? DIST_SAT : DIST_W'(root);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_idx  = 0;
            num_wp     = 0;
            span       = WINDOW_SPAN_RST;
            fail_count = 0;
            answers.delete();
            pending <= 0;
        end
        else
        begin
            // compare a result with the oldest prediction
            if (done)
            begin
                if (answers.size() == 0)
                begin
                    $error("unexpected result: closest_index %0d, nearest_dist %0d",
                           result.closest_index, result.nearest_dist);
                    fail_count++;
                end
                else
                begin
                    oldest = answers.pop_front();
                    if (result.closest_index !== oldest.closest_index)
                    begin
                        $error("closest_index: expected %0d, actual %0d",
                               oldest.closest_index, result.closest_index);
                        fail_count++;
                    end
                    if (result.nearest_dist !== oldest.nearest_dist)
                    begin
                        $error("nearest_dist: expected %0d, actual %0d",
                               oldest.nearest_dist, result.nearest_dist);
                        fail_count++;
                    end
                    if (result.table_empty !== oldest.table_empty)
                    begin
                        $error("table_empty: expected %0d, actual %0d",
                               oldest.table_empty, result.table_empty);
                        fail_count++;
                    end
                end
            end

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NUM_WAYPOINTS: num_wp = 32'(cfg_data);
                    REG_WINDOW_SPAN:   span   = 32'(cfg_data[RANGE_W-1:0]);
                    default: ;
                endcase
            end

            // accepted item
            if (start && !busy)
            begin
                case (cmd.command)
                    CMD_LOAD:
                    begin
                        if (cmd.waypoint_index < MAX_WAYPOINTS_DEF)
                        begin
                            wp_x[cmd.waypoint_index] = 32'(cmd.pos_x);
                            wp_y[cmd.waypoint_index] = 32'(cmd.pos_y);
                        end
                    end
                    CMD_REWIND: track_idx = 32'(cmd.waypoint_index);
                    CMD_QUERY:
                        answers.insert(answers.size(),
                                       nearest_in_window(32'(cmd.pos_x),
                                                         32'(cmd.pos_y)));
                    default: ;
                endcase
            end
            pending <= answers.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wnt_pkg::*;

    // undefined command code, ignored by the block
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   busy;
    wnt_item_t              cmd       = '0;
    logic                   done;
    wnt_result_t            result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    int                     fail_count;
    int                     pending;

    // Stimulus bookkeeping: which entries hold data, lowest possible tracking index
    bit        loaded [MAX_WAYPOINTS_DEF];
    int        track_floor = 0;
    bit        burst       = 1'b0;
    int        path_x0     = 0;
    int        path_y0     = 0;
    int        path_dx     = 100;
    int        path_dy     = 100;
    wnt_item_t last_load   = '0;
    int        sent        = 0;

    always #2 clk = ~clk;

    windowed_nearest_waypoint_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wnt_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic int gap_draw();
        return burst ? 0 : int'($urandom_range(0, 9));
    endfunction

    function automatic wnt_item_t make_item(logic [CMD_W-1:0] op, int idx, int x, int y);
        wnt_item_t it;
        it.command        = op;
        it.waypoint_index = IDX_W'(idx);
        it.pos_x          = COORD_W'(x);
        it.pos_y          = COORD_W'(y);
        return it;
    endfunction

    // Point near the current path, now and then a repeat of the last load or a wild value
    function automatic wnt_item_t path_item(logic [CMD_W-1:0] op, int idx);
        int pick;
        pick = $urandom_range(0, 11);
        if (pick == 0)
            return make_item(op, idx, $urandom, $urandom);
        if (pick == 1)
            return make_item(op, idx, $signed(last_load.pos_x), $signed(last_load.pos_y));
        return make_item(op, idx,
                         path_x0 + idx * path_dx + int'($urandom_range(0, 600)) - 300,
                         path_y0 + idx * path_dy + int'($urandom_range(0, 600)) - 300);
    endfunction

    // Lowest index from which all entries up to the end of the table are loaded
    function automatic int loaded_from(int n);
        int r;
        r = n;
        while (r > 0 && loaded[r-1])
            r--;
        return r;
    endfunction

    // Entered and left at a falling edge; start stays high after the item
    task automatic send_cmd(wnt_item_t it);
        int gap;
        gap = gap_draw();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic load_entry(wnt_item_t it);
        it.command                 = CMD_LOAD;
        loaded[it.waypoint_index]  = 1'b1;
        last_load                  = it;
        send_cmd(it);
    endtask

    task automatic rewind_to(int r);
        track_floor = r;
        send_cmd(make_item(CMD_REWIND, r, $urandom, $urandom));
    endtask

    // Hold off until every query has answered, then let a load settle
    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Run limit
    initial
    begin
        #12000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int n;
        int r;
        int base;
        int i;
        int count;
        int roll;
        int tgt;
        int lo;
        int hi;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed: empty table, ignored code, extremes, ties, past-end windows
        send_cmd(make_item(CMD_QUERY, 0, 0, 0));
        send_cmd(make_item(CMD_NONE, 1023, -1, -1));
        load_entry(make_item(CMD_LOAD, 0, -8388608, -8388608));
        load_entry(make_item(CMD_LOAD, 1, 8388607, 8388607));
        load_entry(make_item(CMD_LOAD, 2, 0, 0));
        load_entry(make_item(CMD_LOAD, 3, 0, 0));
        load_entry(make_item(CMD_LOAD, 4, 100, -100));
        load_entry(make_item(CMD_LOAD, 5, 8388607, -8388608));
        drain();
        write_reg(REG_NUM_WAYPOINTS, 6);
        send_cmd(make_item(CMD_QUERY, 0, 8388607, 8388607));
        send_cmd(make_item(CMD_QUERY, 0, -8388608, -8388608));
        rewind_to(6);
        send_cmd(make_item(CMD_QUERY, 0, 0, 0));
        rewind_to(1023);
        send_cmd(make_item(CMD_QUERY, 1023, 0, 0));
        rewind_to(0);
        drain();
        write_reg(REG_WINDOW_SPAN, 0);
        send_cmd(make_item(CMD_QUERY, 0, 8388607, 8388607));
        drain();
        write_reg(REG_WINDOW_SPAN, 1023);
        send_cmd(make_item(CMD_QUERY, 0, 0, 0));
        rewind_to(5);
        send_cmd(make_item(CMD_QUERY, 0, 8388607, 8388607));

        // Random phases: new table size, range and path each time
        while (sent < 525)
        begin
            case ($urandom_range(0, 9))
                0:       n = 0;
                1:       n = 1;
                2:       n = MAX_WAYPOINTS_DEF;
                3:       n = 2;
                default: n = $urandom_range(3, 64);
            endcase
            case ($urandom_range(0, 7))
                0:       r = 0;
                1:       r = 1023;
                2:       r = 1;
                default: r = $urandom_range(2, 24);
            endcase
            burst   = ($urandom_range(0, 3) == 0);
            path_x0 = int'($urandom_range(0, 8000000)) - 4000000;
            path_y0 = int'($urandom_range(0, 8000000)) - 4000000;
            path_dx = int'($urandom_range(0, 4000)) - 2000;
            path_dy = int'($urandom_range(0, 4000)) - 2000;

            drain();
            write_reg(REG_NUM_WAYPOINTS, n);
            write_reg(REG_WINDOW_SPAN, r);

            // fill the tail of the table so every window reads loaded entries
            base = (n > 40) ? n - int'($urandom_range(8, 40)) : 0;
            for (i = base; i < n; i++)
            begin
                if (!loaded[i])
                    load_entry(path_item(CMD_LOAD, i));
            end
            rewind_to(base);

            count = $urandom_range(20, 60);
            repeat (count)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                begin
                    // robot somewhere along the window ahead
                    tgt = track_floor + int'($urandom_range(0, r));
                    if (tgt > 1023)
                        tgt = 1023;
                    send_cmd(path_item(CMD_QUERY, tgt));
                end
                else if (roll < 72)
                begin
                    if ($urandom_range(0, 4) == 0)
                        tgt = $urandom_range(0, 1023);
                    else
                        tgt = $urandom_range(0, n + 8);
                    if (tgt > 1023)
                        tgt = 1023;
                    load_entry(path_item(CMD_LOAD, tgt));
                end
                else if (roll < 85)
                begin
                    // never rewind onto a window that reaches unloaded entries
                    lo = loaded_from(n);
                    hi = ($urandom_range(0, 4) == 0) ? 1023 : n + 4;
                    if (hi > 1023)
                        hi = 1023;
                    rewind_to($urandom_range(lo, hi));
                end
                else if (roll < 90)
                    send_cmd(make_item(CMD_NONE, $urandom, $urandom, $urandom));
                else if (roll < 93)
                    drain();
                else
                    send_cmd(make_item(CMD_QUERY, $urandom, $urandom, $urandom));
            end
        end

        drain();
        repeat (64) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/wnt_pkg.sv
hw/rtl/wnt_ram.sv
hw/rtl/wnt_ctrl.sv
hw/rtl/wnt_datapath.sv
hw/rtl/windowed_nearest_waypoint_tracker.sv
dv/wnt_checker.sv
dv/tb_top.sv
